// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the matrix store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define MST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("matrix store assertion failed");

// Clocked property that is checked during reset as well.
`define MST_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("matrix store reset assertion failed");

`endif

// ----- src/mst_pkg.sv -----
// Shared types and constants of the matrix store with transpose and reshape.
package mst_pkg;

    // Defaults of the top-level parameters
    localparam int CAPACITY_DEF   = 1024;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int ARG_W     = 11;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 2 * ARG_W;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    // Operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_RESHAPE   = 2'd1,
        OP_TRANSPOSE = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QOUT,
        ST_XWALK,
        ST_XDONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic reshape;
        logic q_start;
        logic q_out;
        logic x_start;
        logic x_step;
        logic x_finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic x_fits;
        logic x_last;
        logic out_free;
    } t_stat;

endpackage

// ----- src/matrix_store_transpose_reshape_unit.sv -----
// Top level of the matrix store with load, reshape, transpose and query.
//
//  channel  | direction | tuser          | tdata
//  s_axis   | in        | operation [1:0]| row_arg, col_arg, value
//  m_axis   | out       | index_ok [0]   | read_value
//
// Load and reshape are taken in the idle state. A query registers its index,
// reads the bank and loads the output register. A transpose walks every
// entry of the active bank once through the single read port and writes
// the other bank. Reset clears shape, fill position, active bank and the
// output valid flag; bank contents are not cleared. While a result beat waits
// on m_axis, other beats are taken; a query waits in ST_QOUT, blocking input.
module matrix_store_transpose_reshape_unit #(
    parameter int CAPACITY   = mst_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = mst_pkg::ELEM_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [10:0] row_arg, [21:11] col_arg, [53:22] value, [55:54] zero
    input  logic [mst_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] operation
    input  logic [mst_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_value
    output logic [mst_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] index_ok
    output logic [0:0]                      m_axis_tuser
);
    import mst_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_ok;

    mst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (t_op'(s_axis_tuser)),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mst_dpath #(.CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_row_arg    (s_axis_tdata[ARG_W-1:0]),
        .i_col_arg    (s_axis_tdata[2*ARG_W-1:ARG_W]),
        .i_value      (s_axis_tdata[2*ARG_W+VAL_W-1:2*ARG_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_read_value (m_axis_tdata),
        .o_index_ok   (out_ok)
    );

    assign m_axis_tuser = out_ok;

endmodule

// ----- src/mst_bank.sv -----
// One bank of element storage: one write port, one registered read port.
module mst_bank #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/mst_ctrl.sv -----
// Controller state machine: sequences loads, reshapes, queries and transposes.
module mst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mst_pkg::t_op  i_op,
    output logic          o_ready,
    input  mst_pkg::t_stat i_stat,
    output mst_pkg::t_cmd  o_cmd
);
    import mst_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_op)
                        OP_LOAD:    o_cmd.load    = 1'b1;
                        OP_RESHAPE: o_cmd.reshape = 1'b1;
                        OP_TRANSPOSE: begin
                            // oversized matrix: transpose is dropped
                            if (i_stat.x_fits) begin
                                o_cmd.x_start = 1'b1;
                                n_state       = ST_XWALK;
                            end
                        end
                        OP_QUERY: begin
                            o_cmd.q_start = 1'b1;
                            n_state       = ST_QREAD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_QREAD: n_state = ST_QOUT;
            ST_QOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.q_out = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_XWALK: begin
                o_cmd.x_step = 1'b1;
                if (i_stat.x_last) begin
                    n_state = ST_XDONE;
                end
            end
            ST_XDONE: begin
                // last copy write lands here, then banks swap
                o_cmd.x_finish = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- src/mst_dpath.sv -----
// Datapath: two banks, matrix shape, transpose address walk and output register.
module mst_dpath #(
    parameter int CAPACITY   = mst_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = mst_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mst_pkg::t_cmd               i_cmd,
    output mst_pkg::t_stat              o_stat,
    input  logic [mst_pkg::ARG_W-1:0]   i_row_arg,
    input  logic [mst_pkg::ARG_W-1:0]   i_col_arg,
    input  logic [mst_pkg::VAL_W-1:0]   i_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mst_pkg::VAL_W-1:0]   o_read_value,
    output logic                        o_index_ok
);
    import mst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    // Architectural state
    logic          r_active;
    logic [ARG_W-1:0] r_rows;
    logic [ARG_W-1:0] r_cols;
    logic [FW-1:0] r_fill;

    // Transpose walk
    logic [AW-1:0]    r_k;
    logic [ARG_W-1:0] r_i;
    logic [ARG_W-1:0] r_j;
    logic [AW-1:0]    r_dst;
    logic [AW-1:0]    r_wr_addr;
    logic             r_wr_pend;

    // Query
    logic [AW-1:0] r_q_idx;
    logic          r_q_ok;

    // Output register
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_ok;

    logic [IDX_W-1:0]      prod;
    logic [IDX_W-1:0]      q_idx;
    logic                  q_ok;
    logic                  ld_en;
    logic                  inmat;
    logic [AW-1:0]         raddr;
    logic [ELEM_WIDTH-1:0] ld_word;
    logic [ELEM_WIDTH-1:0] rd_a;
    logic [ELEM_WIDTH-1:0] rd_b;
    logic [ELEM_WIDTH-1:0] rd_src;
    logic                  we_a;
    logic                  we_b;
    logic [AW-1:0]         waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic signed [ELEM_WIDTH-1:0] rd_s;

    // Shape checks: one 11x11 product each
    assign prod  = IDX_W'(r_rows) * IDX_W'(r_cols);
    assign q_idx = IDX_W'(i_row_arg) * IDX_W'(r_cols) + IDX_W'(i_col_arg);
    assign q_ok  = (i_row_arg < r_rows) && (i_col_arg < r_cols)
                   && (q_idx < IDX_W'(CAPACITY));

    assign ld_en   = i_cmd.load && (r_fill < FW'(CAPACITY));
    assign ld_word = ELEM_WIDTH'(signed'(i_value));
    assign inmat   = (r_i < r_rows) && (r_cols != '0);
    assign raddr   = i_cmd.x_step ? r_k : r_q_idx;
    assign rd_src  = r_active ? rd_b : rd_a;

    // Loads go to the active bank, transpose copies to the other one
    assign we_a  = (ld_en && !r_active) || (r_wr_pend && r_active);
    assign we_b  = (ld_en && r_active) || (r_wr_pend && !r_active);
    assign waddr = ld_en ? r_fill[AW-1:0] : r_wr_addr;
    assign wdata = ld_en ? ld_word : rd_src;

    mst_bank #(.DEPTH(CAPACITY), .WIDTH(ELEM_WIDTH), .AW(AW)) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_a)
    );

    mst_bank #(.DEPTH(CAPACITY), .WIDTH(ELEM_WIDTH), .AW(AW)) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_b)
    );

    // Shape, fill position and active bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rows   <= '0;
            r_cols   <= '0;
            r_fill   <= '0;
        end else begin
            if (ld_en) begin
                r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.reshape) begin
                r_rows <= i_row_arg;
                r_cols <= i_col_arg;
            end
            if (i_cmd.x_finish) begin
                r_active <= ~r_active;
                r_rows   <= r_cols;
                r_cols   <= r_rows;
            end
        end
    end

    // Transpose walk: source index k, element (i,j) goes to j*rows+i
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_start) begin
            r_k   <= '0;
            r_i   <= '0;
            r_j   <= '0;
            r_dst <= '0;
        end else if (i_cmd.x_step) begin
            r_wr_addr <= inmat ? r_dst : r_k;
            r_k       <= r_k + AW'(1);
            if (inmat) begin
                if (r_j == r_cols - ARG_W'(1)) begin
                    r_j   <= '0;
                    r_i   <= r_i + ARG_W'(1);
                    r_dst <= AW'(r_i + ARG_W'(1));
                end else begin
                    r_j   <= r_j + ARG_W'(1);
                    r_dst <= r_dst + AW'(r_rows);
                end
            end
        end
    end

    // Copy write happens in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.x_step;
        end
    end

    // Query index and range flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_q_idx <= q_idx[AW-1:0];
            r_q_ok  <= q_ok;
        end
    end

    // Result register
    assign rd_s = signed'(rd_src);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.q_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_out) begin
            r_out_value <= r_q_ok ? VAL_W'(rd_s) : '0;
            r_out_ok    <= r_q_ok;
        end
    end

    assign o_stat.x_fits   = (prod <= IDX_W'(CAPACITY));
    assign o_stat.x_last   = (r_k == AW'(CAPACITY - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_index_ok   = r_out_ok;

endmodule

// ----- src/mst_checker.sv -----
// Port-level checker for the matrix store, bound to the top level.
`include "assert_macros.svh"

module mst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mst_pkg::OP_W-1:0]      s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mst_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                    m_axis_tuser
);
    import mst_pkg::*;

    logic                 in_beat;
    logic                 q_beat;
    logic                 out_bad;
    logic                 out_stall;
    logic [M_TDATA_W:0]   out_word;

    // Handshake terms used by the properties
    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign q_beat    = in_beat && (s_axis_tuser == OP_QUERY);
    assign out_bad   = m_axis_tvalid && !m_axis_tuser[0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    // Output register is empty straight after reset
    `MST_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // Out-of-range query reports zero
    `MST_ASSERT(a_bad_zero, i_clk, i_rst_n, out_bad |-> (m_axis_tdata == '0))

    // A query keeps the input side busy while it reads the bank
    `MST_ASSERT(a_q_busy, i_clk, i_rst_n, q_beat |=> !s_axis_tready)

    // Beats other than queries never create a result
    `MST_ASSERT(a_no_spurious, i_clk, i_rst_n, (in_beat && !q_beat && !m_axis_tvalid) |=> !m_axis_tvalid)

    // Stalled result holds
    `MST_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> (m_axis_tvalid && $stable(out_word)))

endmodule

bind matrix_store_transpose_reshape_unit mst_checker u_mst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
